// File: hw/rtl/rwc_pkg.sv
package rwc_pkg;

   localparam int SCREEN_HEIGHT = 480;
   localparam int HALF_ROWS     = SCREEN_HEIGHT / 2;

   localparam int ROW_W    = 12;
   localparam int COL_W    = 12;
   localparam int DIR_W    = 18;
   localparam int DIST_W   = 24;
   localparam int PLAYER_W = 24;
   localparam int TEXW_W   = 11;
   localparam int HLOG_W   = 4;
   localparam int TEXEL_W  = 10;
   localparam int FACE_W   = 2;
   localparam int POS_W    = 48;
   localparam int STEP_W   = 27;
   localparam int OPND_W   = 32;
   localparam int PROD_W   = 2 * OPND_W;
   localparam int FRAC_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int MAX_TEX_W  = 1024;
   localparam int MAX_HLOG   = 10;

   // slice height numerator is the screen height in Q16
   localparam int LH_W       = $clog2(SCREEN_HEIGHT * 65536 + 1);
   localparam int DIVIDEND_W = (LH_W > STEP_W) ? LH_W : STEP_W;
   localparam int DIVISOR_W  = (LH_W > DIST_W) ? LH_W : DIST_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int OFS_W      = LH_W - 1;

   localparam logic KIND_COLUMN = 1'b0;
   localparam logic SIDE_X      = 1'b0;

   typedef enum logic [FACE_W-1:0] {
      FACE_EAST  = 2'd0,
      FACE_WEST  = 2'd1,
      FACE_SOUTH = 2'd2,
      FACE_NORTH = 2'd3
   } face_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLAYER_X = 2'd0,
      CSR_PLAYER_Y = 2'd1,
      CSR_TEX_WIDTH = 2'd2,
      CSR_TEX_HLOG = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ALU_NOP,
      ALU_DIV_LOAD,
      ALU_DIV_STEP,
      ALU_MUL
   } alu_op_type;

   typedef enum logic [2:0] {
      OPND_LH,
      OPND_HIT,
      OPND_TX,
      OPND_STEP,
      OPND_POS
   } opnd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LH_LOAD,
      ST_LH_DIV,
      ST_HIT_MUL,
      ST_FRAC,
      ST_TX_MUL,
      ST_STEP_LOAD,
      ST_STEP_DIV,
      ST_POS_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       busy;
      alu_op_type alu_op;
      opnd_type   opnd;
      logic       lat_lh;
      logic       lat_frac;
      logic       lat_txx;
      logic       lat_step;
      logic       finish;
   } ctrl_type;

   typedef struct packed {
      logic [COL_W-1:0]   out_column;
      logic [ROW_W-1:0]   row;
      logic [FACE_W-1:0]  face;
      logic [TEXEL_W-1:0] texel_x;
      logic [TEXEL_W-1:0] texel_y;
      logic [ROW_W-1:0]   row_first;
      logic [ROW_W-1:0]   row_stop;
      logic               pixel_valid;
      logic               last_pixel;
   } rsp_type;

endpackage

// File: hw/rtl/rwc_if.sv
interface rwc_req_if import rwc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [COL_W-1:0]         column;
   logic                     side;
   logic signed [DIR_W-1:0]  dir_x;
   logic signed [DIR_W-1:0]  dir_y;
   logic [DIST_W-1:0]        wall_dist;

   modport source (output valid, kind, column, side, dir_x, dir_y, wall_dist, input ready);
   modport sink (input valid, kind, column, side, dir_x, dir_y, wall_dist, output ready);
endinterface

interface rwc_rsp_if import rwc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COL_W-1:0]   out_column;
   logic [ROW_W-1:0]   row;
   logic [FACE_W-1:0]  face;
   logic [TEXEL_W-1:0] texel_x;
   logic [TEXEL_W-1:0] texel_y;
   logic [ROW_W-1:0]   row_first;
   logic [ROW_W-1:0]   row_stop;
   logic               pixel_valid;
   logic               last_pixel;

   modport source (output valid, out_column, row, face, texel_x, texel_y, row_first,
                   row_stop, pixel_valid, last_pixel, input ready);
   modport sink (input valid, out_column, row, face, texel_x, texel_y, row_first,
                 row_stop, pixel_valid, last_pixel, output ready);
endinterface

interface rwc_csr_if import rwc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/rwc_alu.sv
module rwc_alu import rwc_pkg::*; (
   input  logic                  clock,
   input  alu_op_type            op,
   input  logic [OPND_W-1:0]     opnd_a,
   input  logic [OPND_W-1:0]     opnd_b,
   output logic [DIVIDEND_W-1:0] quo,
   output logic [PROD_W-1:0]     prod
);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;
   logic [PROD_W-1:0]     mul_full;

   // restoring divide, one quotient bit per step
   assign shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff     = {1'b0, shifted} - {2'b00, dvs_ff};
   assign mul_full = opnd_a * opnd_b;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      prod_in = prod_ff;
      case (op)
         ALU_DIV_LOAD: begin
            rem_in = '0;
            quo_in = opnd_a[DIVIDEND_W-1:0];
            dvs_in = opnd_b[DIVISOR_W-1:0];
         end
         ALU_DIV_STEP: begin
            if (diff[DIVISOR_W+1]) begin
               rem_in = shifted[DIVISOR_W-1:0];
               quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
            end else begin
               rem_in = diff[DIVISOR_W-1:0];
               quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
            end
         end
         ALU_MUL: prod_in = mul_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      prod_ff <= prod_in;
   end

   assign quo  = quo_ff;
   assign prod = prod_ff;

endmodule

// File: hw/rtl/rwc_seq.sv
module rwc_seq import rwc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output ctrl_type ctrl
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cnt_last;

   assign cnt_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_LH_LOAD;
         ST_LH_LOAD: begin
            cnt_in   = '0;
            state_in = ST_LH_DIV;
         end
         ST_LH_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) state_in = ST_HIT_MUL;
         end
         ST_HIT_MUL:   state_in = ST_FRAC;
         ST_FRAC:      state_in = ST_TX_MUL;
         ST_TX_MUL:    state_in = ST_STEP_LOAD;
         ST_STEP_LOAD: begin
            cnt_in   = '0;
            state_in = ST_STEP_DIV;
         end
         ST_STEP_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) state_in = ST_POS_MUL;
         end
         ST_POS_MUL: state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl          = '0;
      ctrl.alu_op   = ALU_NOP;
      ctrl.opnd     = OPND_LH;
      ctrl.busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_LH_LOAD: begin
            ctrl.alu_op = ALU_DIV_LOAD;
            ctrl.opnd   = OPND_LH;
         end
         ST_LH_DIV: ctrl.alu_op = ALU_DIV_STEP;
         ST_HIT_MUL: begin
            ctrl.lat_lh = 1'b1;
            ctrl.alu_op = ALU_MUL;
            ctrl.opnd   = OPND_HIT;
         end
         ST_FRAC: ctrl.lat_frac = 1'b1;
         ST_TX_MUL: begin
            ctrl.alu_op = ALU_MUL;
            ctrl.opnd   = OPND_TX;
         end
         ST_STEP_LOAD: begin
            ctrl.lat_txx = 1'b1;
            ctrl.alu_op  = ALU_DIV_LOAD;
            ctrl.opnd    = OPND_STEP;
         end
         ST_STEP_DIV: ctrl.alu_op = ALU_DIV_STEP;
         ST_POS_MUL: begin
            ctrl.lat_step = 1'b1;
            ctrl.alu_op   = ALU_MUL;
            ctrl.opnd     = OPND_POS;
         end
         ST_DONE: ctrl.finish = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/raycast_wall_column_texture_unit.sv
// Textured wall column mapper for a ray-casting renderer.
// req_bus carries column transactions (kind 0: distance, side, ray direction) and
// pixel transactions (kind 1). Every request yields exactly one response on rsp_bus.
// A column transaction computes slice height, clamped first/end rows, face and
// texture column, and sets up the texture step and start position for the rows.
// Each pixel transaction then returns the next row of that column with its texture row.
// csr_bus writes player x/y, texture width and log2 texture height; always ready;
// the user must write only while no transaction is in flight; the block does not check.
// A pixel transaction is answered in the cycle after acceptance, so pixel rows stream
// at one per cycle while the receiver stays ready. A column transaction runs two
// 27-step restoring divisions (slice height, texture step) plus three products,
// all through one shared divide/multiply unit. No request is taken until it responds.
// A single output register holds the response; a new request is taken while it is
// being drained, and a stalled receiver holds off all further requests.
// Reset clears the column state (no rows pending) and loads the register defaults:
// player 0,0, texture width 64, height log2 6.
module raycast_wall_column_texture_unit import rwc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rwc_req_if.sink   req_bus,
   rwc_rsp_if.source rsp_bus,
   rwc_csr_if.sink   csr_bus
);

   ctrl_type ctrl;
   logic     req_accept;
   logic     start;

   logic [OPND_W-1:0]     opnd_a, opnd_b;
   logic [DIVIDEND_W-1:0] quo;
   logic [PROD_W-1:0]     prod;

   // configuration
   logic [PLAYER_W-1:0] player_x_ff, player_y_ff;
   logic [TEXW_W-1:0]   tex_width_ff;
   logic [HLOG_W-1:0]   tex_hlog_ff;
   logic [TEXW_W-1:0]   w_eff;
   logic [HLOG_W-1:0]   hlog_eff;
   logic [TEXEL_W-1:0]  ty_mask;
   logic [DIVIDEND_W-1:0] th_num;

   // latched column request
   logic [COL_W-1:0]        in_col_ff;
   logic                    in_side_ff;
   logic signed [DIR_W-1:0] in_dx_ff, in_dy_ff;
   logic [DIST_W-1:0]       in_d_ff;

   // column working values
   logic [LH_W-1:0]    lh_ff;
   logic [ROW_W-1:0]   first_ff, stop_ff;
   logic [OFS_W-1:0]   offset_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [TEXEL_W-1:0] txx_ff;

   // slice state
   logic [ROW_W-1:0]   row_now_ff, row_end_ff;
   logic [POS_W-1:0]   tex_pos_ff;
   logic [STEP_W-1:0]  tex_step_ff;
   logic [COL_W-1:0]   cur_column_ff;
   logic [FACE_W-1:0]  cur_face_ff;
   logic [TEXEL_W-1:0] cur_texel_x_ff;

   logic      rsp_valid_ff;
   rsp_type   rsp_ff, rsp_in;

   logic [LH_W-1:0]     lh_q;
   logic [OFS_W-1:0]    half_lh;
   logic [ROW_W-1:0]    first_c, stop_c;
   logic [OFS_W-1:0]    offset_c;
   logic signed [DIR_W-1:0] dir_sel;
   logic [PLAYER_W-1:0] player_sel;
   logic [TEXEL_W-1:0]  txx_raw;
   logic [TEXEL_W-1:0]  txx_c;
   logic                flip;
   logic [STEP_W-1:0]   step_c;
   face_type            face_c;
   logic                has_row;
   logic [ROW_W-1:0]    row_next;

   rwc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .ctrl  (ctrl)
   );

   rwc_alu u_alu (
      .clock  (clock),
      .op     (ctrl.alu_op),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .quo    (quo),
      .prod   (prod)
   );

   assign req_bus.ready = !ctrl.busy && (!rsp_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign start         = req_accept && (req_bus.kind == KIND_COLUMN);
   assign csr_bus.ready = 1'b1;

   always_comb begin
      if (tex_width_ff == '0)
         w_eff = TEXW_W'(1);
      else if (tex_width_ff > TEXW_W'(MAX_TEX_W))
         w_eff = TEXW_W'(MAX_TEX_W);
      else
         w_eff = tex_width_ff;
      hlog_eff = (tex_hlog_ff > HLOG_W'(MAX_HLOG)) ? HLOG_W'(MAX_HLOG) : tex_hlog_ff;
   end

   assign ty_mask = TEXEL_W'((TEXEL_W'(1) << hlog_eff) - 1'b1)
                    | ((hlog_eff == HLOG_W'(MAX_HLOG)) ? '1 : '0);
   assign th_num  = (DIVIDEND_W'(1) << 16) << hlog_eff;

   // slice height split into first/end rows and texture start offset
   assign lh_q    = quo[LH_W-1:0];
   assign half_lh = lh_q[LH_W-1:1];

   always_comb begin
      if (half_lh >= OFS_W'(HALF_ROWS)) begin
         first_c  = '0;
         offset_c = half_lh - OFS_W'(HALF_ROWS);
      end else begin
         first_c  = ROW_W'(HALF_ROWS) - ROW_W'(half_lh);
         offset_c = '0;
      end
      if (half_lh >= OFS_W'(SCREEN_HEIGHT - HALF_ROWS))
         stop_c = ROW_W'(SCREEN_HEIGHT - 1);
      else
         stop_c = ROW_W'(HALF_ROWS) + ROW_W'(half_lh);
   end

   // an x-facing hit runs along y, a y-facing hit along x
   assign dir_sel    = (in_side_ff == SIDE_X) ? in_dy_ff : in_dx_ff;
   assign player_sel = (in_side_ff == SIDE_X) ? player_y_ff : player_x_ff;

   assign txx_raw = prod[FRAC_W+TEXEL_W-1:FRAC_W];
   assign flip    = ((in_side_ff == SIDE_X) && (in_dx_ff > 0))
                 || ((in_side_ff != SIDE_X) && (in_dy_ff < 0));
   assign txx_c   = flip ? TEXEL_W'(w_eff - TEXW_W'(txx_raw) - TEXW_W'(1)) : txx_raw;

   // zero slice height leaves step and start position at zero
   assign step_c = (lh_ff == '0) ? '0 : quo[STEP_W-1:0];

   always_comb begin
      if (in_side_ff == SIDE_X)
         face_c = (in_dx_ff > 0) ? FACE_EAST : FACE_WEST;
      else
         face_c = (in_dy_ff > 0) ? FACE_SOUTH : FACE_NORTH;
   end

   always_comb begin
      case (ctrl.opnd)
         OPND_LH: begin
            opnd_a = OPND_W'(SCREEN_HEIGHT * 65536);
            opnd_b = OPND_W'(in_d_ff);
         end
         OPND_HIT: begin
            opnd_a = OPND_W'(dir_sel);
            opnd_b = OPND_W'(in_d_ff);
         end
         OPND_TX: begin
            opnd_a = frac_ff;
            opnd_b = OPND_W'(w_eff);
         end
         OPND_STEP: begin
            opnd_a = OPND_W'(th_num);
            opnd_b = OPND_W'(lh_ff);
         end
         OPND_POS: begin
            opnd_a = OPND_W'(offset_ff);
            opnd_b = OPND_W'(step_c);
         end
         default: begin
            opnd_a = '0;
            opnd_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start) begin
         in_col_ff  <= req_bus.column;
         in_side_ff <= req_bus.side;
         in_dx_ff   <= req_bus.dir_x;
         in_dy_ff   <= req_bus.dir_y;
         in_d_ff    <= (req_bus.wall_dist == '0) ? DIST_W'(1) : req_bus.wall_dist;
      end
      if (ctrl.lat_lh) begin
         lh_ff     <= lh_q;
         first_ff  <= first_c;
         stop_ff   <= stop_c;
         offset_ff <= offset_c;
      end
      if (ctrl.lat_frac)
         frac_ff <= prod[FRAC_W-1:0] + {player_sel[15:0], 16'b0};
      if (ctrl.lat_txx)
         txx_ff <= txx_c;
   end

   assign has_row  = (row_now_ff < row_end_ff);
   assign row_next = row_now_ff + 1'b1;

   always_comb begin
      rsp_in            = '0;
      rsp_in.out_column = cur_column_ff;
      rsp_in.face       = cur_face_ff;
      rsp_in.texel_x    = cur_texel_x_ff;
      if (ctrl.finish) begin
         rsp_in.out_column = in_col_ff;
         rsp_in.face       = face_c;
         rsp_in.texel_x    = txx_ff;
         rsp_in.row_first  = first_ff;
         rsp_in.row_stop   = stop_ff;
      end else if (has_row) begin
         rsp_in.row         = row_now_ff;
         rsp_in.texel_y     = tex_pos_ff[16+TEXEL_W-1:16] & ty_mask;
         rsp_in.pixel_valid = 1'b1;
         rsp_in.last_pixel  = (row_next == row_end_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff    <= '0;
         player_y_ff    <= '0;
         tex_width_ff   <= TEXW_W'(64);
         tex_hlog_ff    <= HLOG_W'(6);
         row_now_ff     <= '0;
         row_end_ff     <= '0;
         tex_pos_ff     <= '0;
         tex_step_ff    <= '0;
         cur_column_ff  <= '0;
         cur_face_ff    <= '0;
         cur_texel_x_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            case (csr_idx_type'(csr_bus.index))
               CSR_PLAYER_X:  player_x_ff  <= csr_bus.wdata[PLAYER_W-1:0];
               CSR_PLAYER_Y:  player_y_ff  <= csr_bus.wdata[PLAYER_W-1:0];
               CSR_TEX_WIDTH: tex_width_ff <= csr_bus.wdata[TEXW_W-1:0];
               CSR_TEX_HLOG:  tex_hlog_ff  <= csr_bus.wdata[HLOG_W-1:0];
               default: ;
            endcase
         end
         if (ctrl.lat_step)
            tex_step_ff <= step_c;
         if (ctrl.finish) begin
            tex_pos_ff     <= prod[POS_W-1:0];
            row_now_ff     <= first_ff;
            row_end_ff     <= stop_ff;
            cur_column_ff  <= in_col_ff;
            cur_face_ff    <= face_c;
            cur_texel_x_ff <= txx_ff;
         end else if (req_accept && !start && has_row) begin
            tex_pos_ff <= tex_pos_ff + POS_W'(tex_step_ff);
            row_now_ff <= row_next;
         end
         if (ctrl.finish || req_accept && !start)
            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish || (req_accept && !start))
         rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_column  = rsp_ff.out_column;
   assign rsp_bus.row         = rsp_ff.row;
   assign rsp_bus.face        = rsp_ff.face;
   assign rsp_bus.texel_x     = rsp_ff.texel_x;
   assign rsp_bus.texel_y     = rsp_ff.texel_y;
   assign rsp_bus.row_first   = rsp_ff.row_first;
   assign rsp_bus.row_stop    = rsp_ff.row_stop;
   assign rsp_bus.pixel_valid = rsp_ff.pixel_valid;
   assign rsp_bus.last_pixel  = rsp_ff.last_pixel;

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      ctrl.busy |-> !req_bus.ready)
      else $error("request taken while a column is in progress");

   a_finish_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_bus.valid)
      else $error("column finished without a response");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      row_now_ff <= row_end_ff)
      else $error("current row passed the end row");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last_pixel |-> rsp_bus.pixel_valid)
      else $error("last pixel flagged on a response without a pixel");

endmodule
